### hdl/ptc_pkg.sv
// ptc_pkg: widths, register codes and the structs passed between the
// compensation pipeline modules. No dependencies.
package ptc_pkg;

	// field widths
	localparam int D_W       = 24;  // raw conversion
	localparam int CAL_W     = 16;  // calibration word
	localparam int CFG_IDX_W = 3;
	localparam int OUT_W     = 32;

	// internal widths, sized to the value ranges
	localparam int DT_W   = 25;  // dT
	localparam int MT_W   = 42;  // dT * C6 (also C3/C4 * dT)
	localparam int DD_W   = 48;  // dT^2, non-negative
	localparam int Q_W    = 18;  // TEMP - 2000
	localparam int TEMP_W = 19;  // first-order TEMP
	localparam int TI_W   = 17;  // Ti
	localparam int TOUT_W = 20;  // TEMP - Ti
	localparam int FO_W   = 36;  // first-order OFF / SENS
	localparam int SQ_W   = 34;  // (TEMP-2000)^2
	localparam int DVL_W  = 19;  // TEMP + 1500
	localparam int DVSQ_W = 36;  // (TEMP+1500)^2
	localparam int IC_W   = 39;  // OFFi / SENSi
	localparam int SO_W   = 41;  // OFF2 / SENS2
	localparam int PLO_W  = 20;  // low slice of SENS2 for the split multiply
	localparam int PPLO_W = D_W + PLO_W;
	localparam int PPHI_W = D_W + 1 + SO_W - PLO_W;
	localparam int PROD_W = PPHI_W + PLO_W;
	localparam int Y_W    = 45;
	localparam int X_W    = 46;

	localparam int N_STAGES = 11;

	localparam int T_REF      = 2000;  // reference temperature, 0.01 degC
	localparam int T_VLOW_OFS = 3500;  // distance from 2000 down to -1500

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SENS     = 3'd0,
		REG_OFF      = 3'd1,
		REG_TCS      = 3'd2,
		REG_TCO      = 3'd3,
		REG_TREF     = 3'd4,
		REG_TEMPSENS = 3'd5,
		REG_VARIANT  = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic [CAL_W-1:0] pressure_sensitivity;
		logic [CAL_W-1:0] pressure_offset;
		logic [CAL_W-1:0] sensitivity_temp_coeff;
		logic [CAL_W-1:0] offset_temp_coeff;
		logic [CAL_W-1:0] reference_temperature;
		logic [CAL_W-1:0] temperature_coeff;
		logic             two_bar;
	} cfg_t;

	// first-order results leaving stage 3
	typedef struct packed {
		logic [D_W-1:0]           d1;
		logic signed [TEMP_W-1:0] temp;
		logic signed [Q_W-1:0]    dlow;
		logic signed [FO_W-1:0]   sens;
		logic signed [FO_W-1:0]   off;
		logic [TI_W-1:0]          ti_lo;
		logic [TI_W-1:0]          ti_hi;
	} first_t;

	// second-order corrected values leaving stage 6
	typedef struct packed {
		logic [D_W-1:0]           d1;
		logic signed [TOUT_W-1:0] temp;
		logic signed [SO_W-1:0]   sens2;
		logic signed [SO_W-1:0]   off2;
	} corr_t;

endpackage

### hdl/ptc_cfg.sv
// ptc_cfg: calibration word and sensor variant registers.
// Depends on ptc_pkg.
module ptc_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	input  logic [ptc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ptc_pkg::CAL_W-1:0]        cfg_data,
	output ptc_pkg::cfg_t                    cfg
);

	ptc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			unique case (ptc_pkg::cfg_reg_t'(cfg_index))
				ptc_pkg::REG_SENS:     cfg_q.pressure_sensitivity   <= cfg_data;
				ptc_pkg::REG_OFF:      cfg_q.pressure_offset        <= cfg_data;
				ptc_pkg::REG_TCS:      cfg_q.sensitivity_temp_coeff <= cfg_data;
				ptc_pkg::REG_TCO:      cfg_q.offset_temp_coeff      <= cfg_data;
				ptc_pkg::REG_TREF:     cfg_q.reference_temperature  <= cfg_data;
				ptc_pkg::REG_TEMPSENS: cfg_q.temperature_coeff      <= cfg_data;
				ptc_pkg::REG_VARIANT:  cfg_q.two_bar                <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

	a_variant_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_index == ptc_pkg::REG_VARIANT) |=> (cfg_q.two_bar == $past(cfg_data[0])))
		else $error("variant register did not take the written word");

endmodule

### hdl/ptc_flow.sv
// ptc_flow: per-stage valid bits and stage enables of the pipeline.
// Depends on ptc_pkg.
module ptc_flow (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           out_ready,
	output logic                           in_ready,
	output logic                           out_valid,
	output logic [ptc_pkg::N_STAGES-1:0]   en
);

	localparam int N = ptc_pkg::N_STAGES;

	logic [N-1:0] vld_q;

	// a stage moves when it is empty or the stage after it moves
	always_comb begin
		en[N-1] = ~vld_q[N-1] | out_ready;
		for (int k = N - 2; k >= 0; k--) begin
			en[k] = ~vld_q[k] | en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < N; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign in_ready  = en[0];
	assign out_valid = vld_q[N-1];

	a_no_empty_stall: assert property (@(posedge clk) disable iff (!arst_n)
		((~en & ~vld_q) == '0))
		else $error("empty stage held back");

	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && en[0]) |=> vld_q[0])
		else $error("accepted word missing from first stage");

	a_word_count: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) |-> ($countones(vld_q) == $past($countones(vld_q))
			+ $past(in_valid && en[0]) - $past(vld_q[N-1] && out_ready)))
		else $error("word lost or duplicated in pipeline");

endmodule

### hdl/ptc_first.sv
// ptc_first: stages 1 to 3, dT, the four products on dT and the
// first-order TEMP, OFF, SENS and Ti candidates. Depends on ptc_pkg.
module ptc_first (
	input  logic                        clk,
	input  logic [2:0]                  en,
	input  ptc_pkg::cfg_t               cfg,
	input  logic [ptc_pkg::D_W-1:0]     raw_pressure,
	input  logic [ptc_pkg::D_W-1:0]     raw_temperature,
	output ptc_pkg::first_t             fo
);

	localparam int D_W    = ptc_pkg::D_W;
	localparam int DT_W   = ptc_pkg::DT_W;
	localparam int MT_W   = ptc_pkg::MT_W;
	localparam int DD_W   = ptc_pkg::DD_W;
	localparam int Q_W    = ptc_pkg::Q_W;
	localparam int TEMP_W = ptc_pkg::TEMP_W;
	localparam int TI_W   = ptc_pkg::TI_W;
	localparam int FO_W   = ptc_pkg::FO_W;

	localparam logic signed [MT_W-1:0]   TBias = MT_W'(2**23 - 1);
	localparam logic signed [TEMP_W-1:0] TRef  = TEMP_W'(ptc_pkg::T_REF);

	// stage 1: dT = D2 - C5*2^8
	logic signed [DT_W-1:0] dt_nx, dt_s1;
	logic [D_W-1:0]         d1_s1;

	assign dt_nx = $signed({1'b0, raw_temperature})
		- $signed({1'b0, cfg.reference_temperature, 8'h00});

	always_ff @(posedge clk) begin
		if (en[0]) begin
			dt_s1 <= dt_nx;
			d1_s1 <= raw_pressure;
		end
	end

	// stage 2: products on dT
	logic signed [MT_W-1:0]   mt_nx, mc3_nx, mc4_nx;
	logic signed [2*DT_W-1:0] dd_full;
	logic signed [MT_W-1:0]   mt_s2, mc3_s2, mc4_s2;
	logic [DD_W-1:0]          dd_s2;
	logic [D_W-1:0]           d1_s2;

	assign mt_nx   = dt_s1 * $signed({1'b0, cfg.temperature_coeff});
	assign mc3_nx  = dt_s1 * $signed({1'b0, cfg.sensitivity_temp_coeff});
	assign mc4_nx  = dt_s1 * $signed({1'b0, cfg.offset_temp_coeff});
	assign dd_full = dt_s1 * dt_s1;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			mt_s2  <= mt_nx;
			mc3_s2 <= mc3_nx;
			mc4_s2 <= mc4_nx;
			dd_s2  <= dd_full[DD_W-1:0];
			d1_s2  <= d1_s1;
		end
	end

	// stage 3: truncating shifts (bias by 2^k-1 when negative)
	logic signed [MT_W-1:0]   mt_sum, mt_shr;
	logic signed [Q_W-1:0]    q_nx;
	logic signed [TEMP_W-1:0] q_ext, temp_nx;
	logic signed [MT_W-1:0]   c3_bias, c3_sum, c3_shr;
	logic signed [MT_W-1:0]   c4_bias, c4_sum, c4_shr;
	logic [FO_W-1:0]          sens_base, off_base;
	logic signed [FO_W-1:0]   sens_tr, off_tr;
	logic [DD_W+1:0]          dd3;
	logic [DD_W+3:0]          dd11;
	logic [TI_W-1:0]          ti_lo_nx, ti_hi_nx;

	assign mt_sum  = mt_s2 + (mt_s2[MT_W-1] ? TBias : '0);
	assign mt_shr  = mt_sum >>> 23;
	assign q_nx    = mt_shr[Q_W-1:0];
	assign q_ext   = q_nx;
	assign temp_nx = q_ext + TRef;

	// SENS: C1*2^15 + C3*dT/2^8, or C1*2^16 + C3*dT/2^7 on the 2 bar part
	assign c3_bias   = !mc3_s2[MT_W-1] ? '0 : (cfg.two_bar ? MT_W'(127) : MT_W'(255));
	assign c3_sum    = mc3_s2 + c3_bias;
	assign c3_shr    = cfg.two_bar ? (c3_sum >>> 7) : (c3_sum >>> 8);
	assign sens_tr   = c3_shr[FO_W-1:0];
	assign sens_base = cfg.two_bar ? FO_W'({cfg.pressure_sensitivity, 16'h0000})
		: FO_W'({cfg.pressure_sensitivity, 15'h0000});

	// OFF: C2*2^16 + C4*dT/2^7, or C2*2^17 + C4*dT/2^6
	assign c4_bias  = !mc4_s2[MT_W-1] ? '0 : (cfg.two_bar ? MT_W'(63) : MT_W'(127));
	assign c4_sum   = mc4_s2 + c4_bias;
	assign c4_shr   = cfg.two_bar ? (c4_sum >>> 6) : (c4_sum >>> 7);
	assign off_tr   = c4_shr[FO_W-1:0];
	assign off_base = cfg.two_bar ? FO_W'({cfg.pressure_offset, 17'h00000})
		: FO_W'({cfg.pressure_offset, 16'h0000});

	// Ti for cold (3*dT^2/2^33 or 11*dT^2/2^35) and warm (dT^2/2^36, 30 bar only)
	assign dd3      = (DD_W+2)'(dd_s2) * 2'd3;
	assign dd11     = (DD_W+4)'(dd_s2) * 4'd11;
	assign ti_lo_nx = cfg.two_bar ? dd11[DD_W+3 -: TI_W] : dd3[DD_W+1 -: TI_W];
	assign ti_hi_nx = cfg.two_bar ? '0 : TI_W'(dd_s2[DD_W-1:36]);

	logic [D_W-1:0]           d1_s3;
	logic signed [TEMP_W-1:0] temp_s3;
	logic signed [Q_W-1:0]    dlow_s3;
	logic signed [FO_W-1:0]   sens_s3, off_s3;
	logic [TI_W-1:0]          ti_lo_s3, ti_hi_s3;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			d1_s3    <= d1_s2;
			temp_s3  <= temp_nx;
			dlow_s3  <= q_nx;
			sens_s3  <= sens_base + sens_tr;
			off_s3   <= off_base + off_tr;
			ti_lo_s3 <= ti_lo_nx;
			ti_hi_s3 <= ti_hi_nx;
		end
	end

	assign fo = '{d1: d1_s3, temp: temp_s3, dlow: dlow_s3, sens: sens_s3,
		off: off_s3, ti_lo: ti_lo_s3, ti_hi: ti_hi_s3};

endmodule

### hdl/ptc_corr.sv
// ptc_corr: stages 4 to 6, squares of the temperature deviations and the
// second-order corrections to TEMP, OFF and SENS. Depends on ptc_pkg.
module ptc_corr (
	input  logic             clk,
	input  logic [2:0]       en,
	input  ptc_pkg::cfg_t    cfg,
	input  ptc_pkg::first_t  fi,
	output ptc_pkg::corr_t   co
);

	localparam int D_W    = ptc_pkg::D_W;
	localparam int Q_W    = ptc_pkg::Q_W;
	localparam int TEMP_W = ptc_pkg::TEMP_W;
	localparam int TI_W   = ptc_pkg::TI_W;
	localparam int TOUT_W = ptc_pkg::TOUT_W;
	localparam int FO_W   = ptc_pkg::FO_W;
	localparam int SQ_W   = ptc_pkg::SQ_W;
	localparam int DVL_W  = ptc_pkg::DVL_W;
	localparam int DVSQ_W = ptc_pkg::DVSQ_W;
	localparam int IC_W   = ptc_pkg::IC_W;
	localparam int SO_W   = ptc_pkg::SO_W;
	localparam int SP_W   = SQ_W + 6;

	localparam logic signed [DVL_W-1:0] VlowOfs = DVL_W'(ptc_pkg::T_VLOW_OFS);

	// stage 4: squares, thresholds, TEMP - Ti
	logic signed [Q_W-1:0]     q;
	logic signed [DVL_W-1:0]   q_x, dvl;
	logic signed [2*Q_W-1:0]   sq_full;
	logic signed [2*DVL_W-1:0] dvsq_full;
	logic signed [TEMP_W-1:0]  temp_in;
	logic signed [TOUT_W-1:0]  temp_x;
	logic [TI_W-1:0]           ti_sel;
	logic [TOUT_W-1:0]         ti_x;
	logic signed [FO_W-1:0]    sens_in, off_in;

	assign q         = fi.dlow;
	assign q_x       = q;
	assign dvl       = q_x + VlowOfs;
	assign sq_full   = q * q;
	assign dvsq_full = dvl * dvl;
	assign temp_in   = fi.temp;
	assign temp_x    = temp_in;
	assign ti_sel    = q[Q_W-1] ? fi.ti_lo : fi.ti_hi;
	assign ti_x      = TOUT_W'(ti_sel);
	assign sens_in   = fi.sens;
	assign off_in    = fi.off;

	logic [D_W-1:0]           d1_s4;
	logic signed [TOUT_W-1:0] tout_s4;
	logic signed [FO_W-1:0]   sens_s4, off_s4;
	logic [SQ_W-1:0]          dsq_s4;
	logic [DVSQ_W-1:0]        dvsq_s4;
	logic                     low_s4, vlow_s4;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			d1_s4   <= fi.d1;
			tout_s4 <= temp_x - ti_x;
			sens_s4 <= sens_in;
			off_s4  <= off_in;
			dsq_s4  <= sq_full[SQ_W-1:0];
			dvsq_s4 <= dvsq_full[DVSQ_W-1:0];
			low_s4  <= q[Q_W-1];       // TEMP < 2000
			vlow_s4 <= dvl[DVL_W-1];   // TEMP < -1500
		end
	end

	// stage 5: OFFi and SENSi
	logic [SP_W-1:0] dsq_x, m3, m5, m31, m63;
	logic [IC_W-1:0] dv7, dv4, offi_nx, sensi_nx;

	assign dsq_x = SP_W'(dsq_s4);
	assign m3    = dsq_x * SP_W'(3);
	assign m5    = dsq_x * SP_W'(5);
	assign m31   = dsq_x * SP_W'(31);
	assign m63   = dsq_x * SP_W'(63);
	assign dv7   = IC_W'(dvsq_s4) * IC_W'(7);
	assign dv4   = IC_W'(dvsq_s4) << 2;

	always_comb begin
		offi_nx  = '0;
		sensi_nx = '0;
		priority if (cfg.two_bar) begin
			if (low_s4) begin
				offi_nx  = IC_W'(m31 >> 3);
				sensi_nx = IC_W'(m63 >> 5);
			end
		end else if (low_s4) begin
			offi_nx  = IC_W'(m3 >> 1) + (vlow_s4 ? dv7 : '0);
			sensi_nx = IC_W'(m5 >> 3) + (vlow_s4 ? dv4 : '0);
		end else begin
			offi_nx  = IC_W'(dsq_x >> 4);
		end
	end

	logic [D_W-1:0]           d1_s5;
	logic signed [TOUT_W-1:0] tout_s5;
	logic signed [FO_W-1:0]   sens_s5, off_s5;
	logic [IC_W-1:0]          offi_s5, sensi_s5;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			d1_s5    <= d1_s4;
			tout_s5  <= tout_s4;
			sens_s5  <= sens_s4;
			off_s5   <= off_s4;
			offi_s5  <= offi_nx;
			sensi_s5 <= sensi_nx;
		end
	end

	// stage 6: OFF2 = OFF - OFFi, SENS2 = SENS - SENSi
	logic signed [SO_W-1:0] off_x, sens_x;
	logic [SO_W-1:0]        offi_x, sensi_x;

	assign off_x   = off_s5;
	assign sens_x  = sens_s5;
	assign offi_x  = SO_W'(offi_s5);
	assign sensi_x = SO_W'(sensi_s5);

	logic [D_W-1:0]           d1_s6;
	logic signed [TOUT_W-1:0] tout_s6;
	logic signed [SO_W-1:0]   sens2_s6, off2_s6;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			d1_s6    <= d1_s5;
			tout_s6  <= tout_s5;
			sens2_s6 <= sens_x - sensi_x;
			off2_s6  <= off_x - offi_x;
		end
	end

	assign co = '{d1: d1_s6, temp: tout_s6, sens2: sens2_s6, off2: off2_s6};

endmodule

### hdl/ptc_press.sv
// ptc_press: stages 7 to 11, D1*SENS2 as two partial products, the shifts
// and the OFF2 subtraction, and the output registers. Depends on ptc_pkg.
module ptc_press (
	input  logic                              clk,
	input  logic [4:0]                        en,
	input  ptc_pkg::cfg_t                     cfg,
	input  ptc_pkg::corr_t                    ci,
	output logic signed [ptc_pkg::OUT_W-1:0]  pressure_comp,
	output logic signed [ptc_pkg::OUT_W-1:0]  temperature_comp
);

	localparam int TOUT_W = ptc_pkg::TOUT_W;
	localparam int SO_W   = ptc_pkg::SO_W;
	localparam int PLO_W  = ptc_pkg::PLO_W;
	localparam int PPLO_W = ptc_pkg::PPLO_W;
	localparam int PPHI_W = ptc_pkg::PPHI_W;
	localparam int PROD_W = ptc_pkg::PROD_W;
	localparam int Y_W    = ptc_pkg::Y_W;
	localparam int X_W    = ptc_pkg::X_W;
	localparam int OUT_W  = ptc_pkg::OUT_W;
	localparam int HI_W   = SO_W - PLO_W;

	localparam logic signed [PROD_W-1:0] PBias = PROD_W'(2**21 - 1);

	// stage 7: SENS2 split into unsigned low and signed high slices
	logic signed [SO_W-1:0]   sens2;
	logic [PLO_W-1:0]         s_lo;
	logic signed [HI_W-1:0]   s_hi;
	logic [PPLO_W-1:0]        pp_lo_nx;
	logic signed [PPHI_W-1:0] pp_hi_nx;

	assign sens2    = ci.sens2;
	assign s_lo     = sens2[PLO_W-1:0];
	assign s_hi     = sens2[SO_W-1:PLO_W];
	assign pp_lo_nx = ci.d1 * s_lo;
	assign pp_hi_nx = $signed({1'b0, ci.d1}) * s_hi;

	logic [PPLO_W-1:0]        pp_lo_s7;
	logic signed [PPHI_W-1:0] pp_hi_s7;
	logic signed [SO_W-1:0]   off2_s7;
	logic signed [TOUT_W-1:0] tout_s7;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			pp_lo_s7 <= pp_lo_nx;
			pp_hi_s7 <= pp_hi_nx;
			off2_s7  <= ci.off2;
			tout_s7  <= ci.temp;
		end
	end

	// stage 8: recombine the partial products
	logic [PROD_W-1:0] hi_x, lo_x;

	assign hi_x = {pp_hi_s7, {PLO_W{1'b0}}};
	assign lo_x = PROD_W'(pp_lo_s7);

	logic signed [PROD_W-1:0] prod_s8;
	logic signed [SO_W-1:0]   off2_s8;
	logic signed [TOUT_W-1:0] tout_s8;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			prod_s8 <= hi_x + lo_x;
			off2_s8 <= off2_s7;
			tout_s8 <= tout_s7;
		end
	end

	// stage 9: D1*SENS2 / 2^21, toward zero
	logic signed [PROD_W-1:0] prod_sum, prod_shr;

	assign prod_sum = prod_s8 + (prod_s8[PROD_W-1] ? PBias : '0);
	assign prod_shr = prod_sum >>> 21;

	logic signed [Y_W-1:0]    y_s9;
	logic signed [SO_W-1:0]   off2_s9;
	logic signed [TOUT_W-1:0] tout_s9;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			y_s9    <= prod_shr[Y_W-1:0];
			off2_s9 <= off2_s8;
			tout_s9 <= tout_s8;
		end
	end

	// stage 10: subtract OFF2
	logic signed [X_W-1:0] y_x, off_x;

	assign y_x   = y_s9;
	assign off_x = off2_s9;

	logic signed [X_W-1:0]    x_s10;
	logic signed [TOUT_W-1:0] tout_s10;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			x_s10    <= y_x - off_x;
			tout_s10 <= tout_s9;
		end
	end

	// stage 11: / 2^13 (30 bar) or / 2^15 (2 bar), toward zero
	logic signed [X_W-1:0]   x_bias, x_sum, x_shr;
	logic signed [OUT_W-1:0] t_x;

	assign x_bias = !x_s10[X_W-1] ? '0 : (cfg.two_bar ? X_W'(2**15 - 1) : X_W'(2**13 - 1));
	assign x_sum  = x_s10 + x_bias;
	assign x_shr  = cfg.two_bar ? (x_sum >>> 15) : (x_sum >>> 13);
	assign t_x    = tout_s10;

	logic signed [OUT_W-1:0] p_s11, t_s11;

	always_ff @(posedge clk) begin
		if (en[4]) begin
			p_s11 <= x_shr[OUT_W-1:0];
			t_s11 <= t_x;
		end
	end

	assign pressure_comp    = p_s11;
	assign temperature_comp = t_s11;

endmodule

### hdl/pressure_temp_compensation_unit.sv
// Second-order temperature compensated pressure: top level. out_valid rises when an accepted
// conversion word reaches the output register, and the word leaves when out_ready is high;
// throughput is one word per cycle, and only a full pipe with out_ready low holds the input.
// Depth: three multiplier ranks (products on dT, squares of the temperature deviations,
// split D1*SENS2 partial products), each registered, plus the shift and add stages.
// arst_n clears the calibration registers and empties the pipe; data regs are not reset.
module pressure_temp_compensation_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	// conversion word in
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [ptc_pkg::D_W-1:0]           raw_pressure,
	input  logic [ptc_pkg::D_W-1:0]           raw_temperature,
	// compensated word out
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [ptc_pkg::OUT_W-1:0]  pressure_comp,
	output logic signed [ptc_pkg::OUT_W-1:0]  temperature_comp,
	// calibration write port
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ptc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ptc_pkg::CAL_W-1:0]         cfg_data
);

	ptc_pkg::cfg_t                 cfg;
	ptc_pkg::first_t               first_w;
	ptc_pkg::corr_t                corr_w;
	logic [ptc_pkg::N_STAGES-1:0]  en;

	// Calibration writes are always taken; the block expects them only while idle,
	// so every stage sees the same coefficients for the whole life of a word.
	assign cfg_ready = 1'b1;

	ptc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Valid bits travel with the data. Each stage loads whenever it is empty or
	// its successor moves, so bubbles close up and input is still taken while a
	// finished word waits at the output register.
	ptc_flow u_flow (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.out_ready (out_ready),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.en        (en)
	);

	// Stages 1-3: dT, products on dT, first-order TEMP / OFF / SENS, Ti choices.
	ptc_first u_first (
		.clk             (clk),
		.en              (en[2:0]),
		.cfg             (cfg),
		.raw_pressure    (raw_pressure),
		.raw_temperature (raw_temperature),
		.fo              (first_w)
	);

	// Stages 4-6: warm, cold and very cold corrections, OFF2 and SENS2.
	ptc_corr u_corr (
		.clk (clk),
		.en  (en[5:3]),
		.cfg (cfg),
		.fi  (first_w),
		.co  (corr_w)
	);

	// Stages 7-11: pressure product, scaling and the output register.
	ptc_press u_press (
		.clk              (clk),
		.en               (en[10:6]),
		.cfg              (cfg),
		.ci               (corr_w),
		.pressure_comp    (pressure_comp),
		.temperature_comp (temperature_comp)
	);

endmodule
